// ----- hw/rtl/umed_pkg.sv -----
// Shared types and constants for the USB-MIDI event decoder.
// Used by the front classifier, the packet queue, the back end and the top level.
package umed_pkg;

    localparam int LEN_W = 9;
    localparam int FILTER_W = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    localparam logic [3:0] CODE_SYSEX_CONT = 4'h4;
    localparam logic [3:0] CODE_SYSEX_END1 = 4'h5;
    localparam logic [3:0] CODE_SYSEX_END3 = 4'h7;
    localparam logic [3:0] CODE_NOTE_OFF = 4'h8;
    localparam logic [3:0] CODE_NOTE_ON = 4'h9;
    localparam logic [3:0] CODE_PITCH_BEND = 4'hE;
    localparam logic [3:0] CODE_SINGLE_BYTE = 4'hF;

    typedef enum logic [3:0] {
        KIND_NOTE_OFF = 4'd0,
        KIND_NOTE_ON = 4'd1,
        KIND_POLY_PRESSURE = 4'd2,
        KIND_CONTROL = 4'd3,
        KIND_PROGRAM = 4'd4,
        KIND_AFTERTOUCH = 4'd5,
        KIND_PITCH_BEND = 4'd6,
        KIND_SYSEX = 4'd7,
        KIND_REALTIME = 4'd8
    } kind_t;

    typedef enum logic [2:0] {
        OP_IGNORE,
        OP_VOICE,
        OP_APPEND,
        OP_END,
        OP_SINGLE
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [1:0]  nbytes;
        kind_t       kind;
        logic [4:0]  chan;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  b3;
    } entry_t;

endpackage

// ----- hw/rtl/umed_front.sv -----
// Front classifier: turns a raw packet into a queue entry.
// Depends on umed_pkg; applies the channel filter and the status check.
module umed_front (
    input  logic [7:0]                 header_byte,
    input  logic [7:0]                 status_byte,
    input  logic [7:0]                 first_data,
    input  logic [7:0]                 second_data,
    input  logic [umed_pkg::FILTER_W-1:0] channel_filter,
    output umed_pkg::entry_t           entry
);
    import umed_pkg::*;

    logic [3:0] code;
    logic [4:0] chan;
    logic       pass;

    assign code = header_byte[3:0];
    assign chan = 5'({1'b0, status_byte[3:0]}) + 5'd1;
    assign pass = ((channel_filter == '0) || (channel_filter == chan))
        && (status_byte[7:4] == code);

    always_comb
    begin
        entry.op = OP_IGNORE;
        entry.nbytes = 2'd0;
        entry.kind = kind_t'(code - CODE_NOTE_OFF);
        entry.chan = chan;
        entry.b1 = status_byte;
        entry.b2 = first_data;
        entry.b3 = second_data;
        if ((code == CODE_NOTE_ON) && (second_data == 8'd0))
        begin
            entry.kind = KIND_NOTE_OFF;
        end
        if (code inside {[CODE_NOTE_OFF:CODE_PITCH_BEND]})
        begin
            entry.op = pass ? OP_VOICE : OP_IGNORE;
        end
        else if (code == CODE_SYSEX_CONT)
        begin
            entry.op = OP_APPEND;
            entry.nbytes = 2'd3;
        end
        else if (code inside {[CODE_SYSEX_END1:CODE_SYSEX_END3]})
        begin
            entry.op = OP_END;
            entry.nbytes = 2'(code - CODE_SYSEX_CONT);
        end
        else if (code == CODE_SINGLE_BYTE)
        begin
            entry.op = OP_SINGLE;
            entry.nbytes = 2'd1;
        end
    end

endmodule

// ----- hw/rtl/umed_queue.sv -----
// Two-entry queue between the front classifier and the back end.
// Depends on umed_pkg for the entry type and depth constants.
module umed_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  umed_pkg::entry_t     push_entry,
    input  logic                 pop,
    output logic                 full,
    output logic                 not_empty,
    output umed_pkg::entry_t     head
);
    import umed_pkg::*;

    entry_t                   slots_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0]   count_reg;
    logic [QUEUE_PTR_W-1:0]   wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]   count_next;

    assign full = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("Queue count exceeds its depth.");
    assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("Request pushed into a full queue.");
    assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !not_empty))
        else $error("Request popped from an empty queue.");

endmodule

// ----- hw/rtl/umed_back.sv -----
// Back end: applies each queued request to the sysex length and held message state.
// Depends on umed_pkg; drives the output register of the result channel.
module umed_back #(
    parameter int SYSEX_MAX = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_not_empty,
    input  umed_pkg::entry_t     q_head,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 accepted,
    output logic [3:0]           message_kind,
    output logic [4:0]           message_channel,
    output logic [8:0]           message_first,
    output logic [7:0]           message_second,
    output logic [1:0]           stored_count,
    output logic [7:0]           stored_position,
    output logic [7:0]           stored_byte_a,
    output logic [7:0]           stored_byte_b,
    output logic [7:0]           stored_byte_c
);
    import umed_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(SYSEX_MAX);

    logic [LEN_W-1:0] sysex_length_reg;
    logic [LEN_W-1:0] sysex_length_next;
    kind_t            held_kind_reg;
    kind_t            held_kind_next;
    logic [4:0]       held_channel_reg;
    logic [4:0]       held_channel_next;
    logic [8:0]       held_first_reg;
    logic [8:0]       held_first_next;
    logic [7:0]       held_second_reg;
    logic [7:0]       held_second_next;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic             acc_reg;
    logic             acc_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic [7:0]       pos_reg;
    logic [7:0]       pos_next;
    logic [7:0]       byte_a_reg;
    logic [7:0]       byte_a_next;
    logic [7:0]       byte_b_reg;
    logic [7:0]       byte_b_next;
    logic [7:0]       byte_c_reg;
    logic [7:0]       byte_c_next;

    logic [1:0]       want;
    logic [1:0]       store;
    logic [LEN_W-1:0] room;
    logic [LEN_W-1:0] grown_len;

    assign q_pop = q_not_empty && (!out_valid_reg || !out_stall);

    always_comb
    begin
        want = 2'd0;
        if ((q_head.op == OP_APPEND) || (q_head.op == OP_END))
        begin
            want = q_head.nbytes;
        end
        else if ((q_head.op == OP_SINGLE) && (sysex_length_reg != '0))
        begin
            want = 2'd1;
        end
        room = MAX_LEN - sysex_length_reg;
        if (sysex_length_reg >= MAX_LEN)
        begin
            store = 2'd0;
        end
        else if (LEN_W'(want) <= room)
        begin
            store = want;
        end
        else
        begin
            store = room[1:0];
        end
        grown_len = sysex_length_reg + LEN_W'(store);
    end

    always_comb
    begin
        sysex_length_next = sysex_length_reg;
        held_kind_next = held_kind_reg;
        held_channel_next = held_channel_reg;
        held_first_next = held_first_reg;
        held_second_next = held_second_reg;
        acc_next = acc_reg;
        count_next = count_reg;
        pos_next = pos_reg;
        byte_a_next = byte_a_reg;
        byte_b_next = byte_b_reg;
        byte_c_next = byte_c_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (q_pop)
        begin
            out_valid_next = 1'b1;
            acc_next = 1'b0;
            count_next = store;
            pos_next = (store != 2'd0) ? sysex_length_reg[7:0] : 8'd0;
            byte_a_next = (store >= 2'd1) ? q_head.b1 : 8'd0;
            byte_b_next = (store >= 2'd2) ? q_head.b2 : 8'd0;
            byte_c_next = (store == 2'd3) ? q_head.b3 : 8'd0;
            case (q_head.op)
                OP_VOICE:
                begin
                    held_kind_next = q_head.kind;
                    held_channel_next = q_head.chan;
                    held_first_next = {1'b0, q_head.b2};
                    held_second_next = q_head.b3;
                    acc_next = 1'b1;
                end
                OP_APPEND:
                begin
                    sysex_length_next = grown_len;
                end
                OP_END:
                begin
                    held_kind_next = KIND_SYSEX;
                    held_first_next = grown_len;
                    sysex_length_next = '0;
                    acc_next = 1'b1;
                end
                OP_SINGLE:
                begin
                    if (sysex_length_reg != '0)
                    begin
                        sysex_length_next = grown_len;
                    end
                    else
                    begin
                        held_kind_next = KIND_REALTIME;
                        held_channel_next = q_head.chan;
                        held_first_next = {1'b0, q_head.b2};
                        held_second_next = q_head.b3;
                        acc_next = 1'b1;
                    end
                end
                default:
                begin
                    acc_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sysex_length_reg <= '0;
            held_kind_reg <= KIND_NOTE_OFF;
            held_channel_reg <= '0;
            held_first_reg <= '0;
            held_second_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sysex_length_reg <= sysex_length_next;
            held_kind_reg <= held_kind_next;
            held_channel_reg <= held_channel_next;
            held_first_reg <= held_first_next;
            held_second_reg <= held_second_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        count_reg <= count_next;
        pos_reg <= pos_next;
        byte_a_reg <= byte_a_next;
        byte_b_reg <= byte_b_next;
        byte_c_reg <= byte_c_next;
    end

    assign out_valid = out_valid_reg;
    assign accepted = acc_reg;
    assign message_kind = held_kind_reg;
    assign message_channel = held_channel_reg;
    assign message_first = held_first_reg;
    assign message_second = held_second_reg;
    assign stored_count = count_reg;
    assign stored_position = pos_reg;
    assign stored_byte_a = byte_a_reg;
    assign stored_byte_b = byte_b_reg;
    assign stored_byte_c = byte_c_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        sysex_length_reg <= MAX_LEN)
        else $error("Sysex length exceeds its limit.");
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && (q_head.op == OP_END)) |=> (sysex_length_reg == '0))
        else $error("Sysex length not cleared after an end request.");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (count_reg == 2'd0)) |-> (pos_reg == 8'd0 && byte_a_reg == 8'd0))
        else $error("Stored fields set with no stored bytes.");
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && (q_head.op == OP_IGNORE)) |=> (!acc_reg && $stable(held_kind_reg)))
        else $error("Ignored request changed the held message.");

endmodule

// ----- hw/rtl/usb_midi_event_decoder.sv -----
// USB-MIDI event decoder top level: filter register, classifier, queue and back end.
// Depends on umed_pkg, umed_front, umed_queue and umed_back.
// A packet is registered in a queue slot and then in the output register.
// Throughput: one packet per cycle while out_stall is low and the queue is not full.
// Reset clears the channel filter, the sysex length, the held message and the queue.
module usb_midi_event_decoder #(
    parameter int SYSEX_MAX = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  header_byte,
    input  logic [7:0]  status_byte,
    input  logic [7:0]  first_data,
    input  logic [7:0]  second_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        accepted,
    output logic [3:0]  message_kind,
    output logic [4:0]  message_channel,
    output logic [8:0]  message_first,
    output logic [7:0]  message_second,
    output logic [1:0]  stored_count,
    output logic [7:0]  stored_position,
    output logic [7:0]  stored_byte_a,
    output logic [7:0]  stored_byte_b,
    output logic [7:0]  stored_byte_c
);
    import umed_pkg::*;

    logic [FILTER_W-1:0] channel_filter_reg;
    logic [FILTER_W-1:0] channel_filter_next;
    entry_t              front_entry;
    entry_t              q_head;
    logic                q_full;
    logic                q_not_empty;
    logic                q_pop;
    logic                push;

    assign cfg_ready = 1'b1;
    assign channel_filter_next = (cfg_valid && cfg_ready) ? cfg_data : channel_filter_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_filter_reg <= '0;
        end
        else
        begin
            channel_filter_reg <= channel_filter_next;
        end
    end

    assign in_stall = q_full;
    assign push = in_valid && !in_stall;

    umed_front u_front (
        .header_byte    (header_byte),
        .status_byte    (status_byte),
        .first_data     (first_data),
        .second_data    (second_data),
        .channel_filter (channel_filter_reg),
        .entry          (front_entry)
    );

    umed_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (front_entry),
        .pop        (q_pop),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    umed_back #(
        .SYSEX_MAX (SYSEX_MAX)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_not_empty     (q_not_empty),
        .q_head          (q_head),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .accepted        (accepted),
        .message_kind    (message_kind),
        .message_channel (message_channel),
        .message_first   (message_first),
        .message_second  (message_second),
        .stored_count    (stored_count),
        .stored_position (stored_position),
        .stored_byte_a   (stored_byte_a),
        .stored_byte_b   (stored_byte_b),
        .stored_byte_c   (stored_byte_c)
    );

endmodule
